@@ sv/fqs_pkg.sv @@
`default_nettype none

package fqs_pkg;

  localparam int DepthDef     = 16;
  localparam int WordWidthDef = 32;
  localparam int MaxResults   = 16;

  localparam int CmdW    = 3;
  localparam int ValueW  = 32;
  localparam int PosW    = 4;
  localparam int PopCntW = 5;
  localparam int StatusW = 3;
  localparam int OccW    = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_POP_MANY = 3'd2,
    CMD_READ_AT  = 3'd3,
    CMD_FIND     = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } stat_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } fsm_t;

  // per-cell controls: shift in from the right-hand neighbour, or take the pushed word
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/fqs_cell.sv @@
`default_nettype none

module fqs_cell #(
  parameter int WordWidth = 32
) (
  input  wire logic                  clk,
  input  wire fqs_pkg::cell_ctl_t    ctl,
  input  wire logic [WordWidth-1:0]  push_word,
  input  wire logic [WordWidth-1:0]  right_word,
  input  wire logic [WordWidth-1:0]  key,
  output logic      [WordWidth-1:0]  word,
  output logic                       match
);
  import fqs_pkg::*;

  logic [WordWidth-1:0] word_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r <= push_word;
    end else if (ctl.shift) begin
      word_r <= right_word;
    end
  end

  assign word  = word_r;
  assign match = (word_r == key);

endmodule

`default_nettype wire

@@ sv/fifo_queue_with_search_core.sv @@
// Bounded first-in first-out queue of words with positional read and search.
// Input channel: in_valid / in_stall carrying in_command, in_value, in_position
// and in_pop_count. Result channel: out_valid / out_stall carrying the word,
// found position, status, occupancy, empty flag, head and tail words and last.
// The words sit in a row of cells, head in the first cell; a pop shifts every
// cell one step towards the head, a push loads the cell at the fill count, and
// a find compares the key in every cell at once.
// Latency: a result appears in the cycle after its request is accepted.
// Throughput when not stalled: one request per cycle for push, pop, read, find
// and clear; a pop-several request gives one result per cycle for its
// min(pop_count, occupancy, 16) results and holds the input stalled until the
// last is issued. Occupancy and the empty flag come from the fill count, and
// head and tail words from the cells; all show the queue as it stands after
// the action of the result on display. While out_valid is high and out_stall
// is set, the result and the queue hold and in_stall stays high. Reset empties
// the queue at once; the cells are not cleared, so no sweep follows reset.
`default_nettype none

module fifo_queue_with_search_core #(
  parameter int Depth     = fqs_pkg::DepthDef,
  parameter int WordWidth = fqs_pkg::WordWidthDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fqs_pkg::CmdW-1:0]     in_command,
  input  wire logic [fqs_pkg::ValueW-1:0]   in_value,
  input  wire logic [fqs_pkg::PosW-1:0]     in_position,
  input  wire logic [fqs_pkg::PopCntW-1:0]  in_pop_count,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fqs_pkg::ValueW-1:0]        out_data_word,
  output logic [fqs_pkg::PosW-1:0]          out_found_position,
  output logic [fqs_pkg::StatusW-1:0]       out_status,
  output logic [fqs_pkg::OccW-1:0]          out_occupancy,
  output logic                              out_is_empty,
  output logic [fqs_pkg::ValueW-1:0]        out_head_word,
  output logic [fqs_pkg::ValueW-1:0]        out_tail_word,
  output logic                              out_last
);
  import fqs_pkg::*;

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam int RW = $clog2(MaxResults + 1);
  localparam int NW = (CW > PopCntW) ? ((CW > RW) ? CW : RW) : ((PopCntW > RW) ? PopCntW : RW);

  // state
  fsm_t                 state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic                 out_valid_r;
  logic [ValueW-1:0]    out_data_r;
  logic [PosW-1:0]      out_pos_r;
  stat_t                out_status_r;
  logic                 out_last_r;

  // cell row
  cell_ctl_t            ctl [Depth];
  logic [WordWidth-1:0] cell_word [Depth];
  logic [Depth-1:0]     cell_match;
  logic [WordWidth-1:0] key;

  // handshake
  logic                 out_free;
  logic                 in_acc;
  logic                 drain_step;

  // decode
  cmd_t                 cmd;
  logic [NW-1:0]        n_run;
  logic                 push_en, pop_en, clr_en;
  logic                 res_load;
  logic [WordWidth-1:0] res_word;
  logic [AW-1:0]        res_pos;
  stat_t                res_status;
  logic                 res_last;

  // search
  logic [Depth-1:0]     live;
  logic                 hit;
  logic [AW-1:0]        hit_idx;
  logic [AW-1:0]        rd_idx;
  logic [AW-1:0]        tail_idx;

  assign key      = WordWidth'(in_value);
  assign cmd      = cmd_t'(in_command);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign drain_step = (state_r == ST_DRAIN) && out_free;

  // words popped by a pop-several request, clamped to the count and the result limit
  always_comb begin
    n_run = NW'(in_pop_count);
    if (n_run > NW'(count_r)) begin
      n_run = NW'(count_r);
    end
    if (n_run > NW'(MaxResults)) begin
      n_run = NW'(MaxResults);
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      live[i] = (CW'(i) < count_r);
    end
  end

  // lowest live cell that matches
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (cell_match[i] && live[i]) begin
        hit     = 1'b1;
        hit_idx = AW'(i);
      end
    end
  end

  assign rd_idx   = AW'(in_position);
  assign tail_idx = AW'(count_r - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_POP_MANY && count_r != '0 && n_run > NW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_step && rem_r == RW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // actions and result
  always_comb begin
    push_en    = 1'b0;
    pop_en     = 1'b0;
    clr_en     = 1'b0;
    res_load   = 1'b0;
    res_word   = '0;
    res_pos    = '0;
    res_status = STAT_OK;
    res_last   = 1'b1;
    rem_nxt    = rem_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_load = 1'b1;
          case (cmd)
            CMD_PUSH: begin
              if (count_r == CW'(Depth)) begin
                res_status = STAT_FULL;
              end else begin
                push_en = 1'b1;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                pop_en   = 1'b1;
                res_word = cell_word[0];
              end
            end
            CMD_POP_MANY: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else if (n_run != '0) begin
                pop_en   = 1'b1;
                res_word = cell_word[0];
                res_last = (n_run == NW'(1));
                rem_nxt  = RW'(n_run - NW'(1));
              end
            end
            CMD_READ_AT: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else if (32'(in_position) >= 32'(count_r)) begin
                res_status = STAT_BAD_POS;
              end else begin
                res_word = cell_word[rd_idx];
              end
            end
            CMD_FIND: begin
              if (hit) begin
                res_pos = hit_idx;
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            CMD_CLEAR: begin
              clr_en = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (drain_step) begin
          res_load = 1'b1;
          pop_en   = 1'b1;
          res_word = cell_word[0];
          res_last = (rem_r == RW'(1));
          rem_nxt  = rem_r - RW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (clr_en) begin
      count_nxt = '0;
    end else if (push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  genvar g;
  generate
    for (g = 0; g < Depth; g++) begin : g_cell
      logic [WordWidth-1:0] right;
      if (g == Depth - 1) begin : g_end
        assign right = '0;
      end else begin : g_mid
        assign right = cell_word[g+1];
      end
      assign ctl[g].shift = pop_en;
      assign ctl[g].load  = push_en && (count_r == CW'(g));
      fqs_cell #(
        .WordWidth (WordWidth)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl[g]),
        .push_word  (key),
        .right_word (right),
        .key        (key),
        .word       (cell_word[g]),
        .match      (cell_match[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r   <= ValueW'(res_word);
      out_pos_r    <= PosW'(res_pos);
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_word      = out_data_r;
  assign out_found_position = out_pos_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;
  assign out_occupancy      = OccW'(count_r);
  assign out_is_empty       = (count_r == '0);
  assign out_head_word      = (count_r == '0) ? '0 : ValueW'(cell_word[0]);
  assign out_tail_word      = (count_r == '0) ? '0 : ValueW'(cell_word[tail_idx]);

endmodule

`default_nettype wire

@@ sv/fqs_checker.sv @@
`default_nettype none

module fqs_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [fqs_pkg::CmdW-1:0]     in_command,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [fqs_pkg::ValueW-1:0]   out_data_word,
  input  wire logic [fqs_pkg::PosW-1:0]     out_found_position,
  input  wire logic [fqs_pkg::StatusW-1:0]  out_status,
  input  wire logic [fqs_pkg::OccW-1:0]     out_occupancy,
  input  wire logic                         out_is_empty,
  input  wire logic [fqs_pkg::ValueW-1:0]   out_head_word,
  input  wire logic [fqs_pkg::ValueW-1:0]   out_tail_word,
  input  wire logic                         out_last
);
  import fqs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_word) && $stable(out_last))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (out_occupancy == '0))
    else $error("empty flag disagrees with occupancy");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_head_word == '0 && out_tail_word == '0)
    else $error("empty queue shows a head or tail word");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_NOT_FOUND |-> out_found_position == '0 && out_data_word == '0)
    else $error("failed find carries a position or word");

  // a clear request answers in the next cycle with an empty queue
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_CLEAR |=> out_valid && out_is_empty && out_last)
    else $error("clear did not empty the queue");

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_command         (in_command),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_data_word      (out_data_word),
  .out_found_position (out_found_position),
  .out_status         (out_status),
  .out_occupancy      (out_occupancy),
  .out_is_empty       (out_is_empty),
  .out_head_word      (out_head_word),
  .out_tail_word      (out_tail_word),
  .out_last           (out_last)
);

`default_nettype wire
